// ===== rtl/core/abatt_pkg.sv =====
// ----------------------------------------------------------------------------
// abatt_pkg
// Shared types and constants for the beam attenuation datapath.
// ----------------------------------------------------------------------------
package abatt_pkg;

    localparam int POS_W   = 32;   // position field width
    localparam int ANG_W   = 16;   // heading / width field width
    localparam int LOSS_W  = 16;
    localparam int TOTAL_W = 17;
    localparam int ZW      = 26;   // CORDIC angle, 1/65536 degree
    localparam int ATAN_W  = 22;
    localparam int DIFF_W  = 25;   // absolute angle difference
    localparam int FOLD_W  = 24;   // folded difference, <= 180 degrees
    localparam int NUM_W   = 26;   // 3 * folded difference
    localparam int QBITS   = 10;   // in-beam quotient never exceeds 768
    localparam int DIV_STAGES = QBITS / 2;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(180 * 65536);
    localparam logic [DIFF_W-1:0]    FULL_TURN    = DIFF_W'(360 * 65536);
    localparam logic signed [ANG_W-1:0] HEADING_LIMIT = 16'sd23040;
    localparam logic [ANG_W-1:0]     OMNI_WIDTH   = 16'd46080;
    localparam logic [LOSS_W-1:0]    MAX_ATT_RESET = 16'd5120;

    // APB register map
    localparam logic [1:0] ADDR_MAX_ATT = 2'd0;

    // atan(2^-i) in 1/65536 degree, rounded
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:31] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234378,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    // per-plane values carried alongside the CORDIC
    typedef struct packed {
        logic signed [ANG_W-1:0] h_az;
        logic [ANG_W-1:0]        w_az;
        logic signed [ANG_W-1:0] h_el;
        logic [ANG_W-1:0]        w_el;
    } side_t;

    // result selection carried alongside the divider
    typedef struct packed {
        logic              use_q;
        logic [LOSS_W-1:0] fixed;
    } sel_t;

endpackage

// ===== rtl/core/abatt_if.sv =====
// ----------------------------------------------------------------------------
// abatt_if
// Valid/ready channels for pair requests and loss results.
// ----------------------------------------------------------------------------
interface abatt_in_if
    import abatt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] tx_pos_x;
    logic signed [POS_W-1:0] tx_pos_y;
    logic signed [POS_W-1:0] tx_pos_z;
    logic signed [POS_W-1:0] rx_pos_x;
    logic signed [POS_W-1:0] rx_pos_y;
    logic signed [POS_W-1:0] rx_pos_z;
    logic signed [ANG_W-1:0] azimuth_heading;
    logic [ANG_W-1:0]        azimuth_width;
    logic signed [ANG_W-1:0] elevation_heading;
    logic [ANG_W-1:0]        elevation_width;

    modport source (output valid, tx_pos_x, tx_pos_y, tx_pos_z, rx_pos_x, rx_pos_y,
                    rx_pos_z, azimuth_heading, azimuth_width, elevation_heading,
                    elevation_width, input ready);
    modport sink   (input valid, tx_pos_x, tx_pos_y, tx_pos_z, rx_pos_x, rx_pos_y,
                    rx_pos_z, azimuth_heading, azimuth_width, elevation_heading,
                    elevation_width, output ready);
endinterface

interface abatt_out_if
    import abatt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LOSS_W-1:0]  azimuth_loss;
    logic [LOSS_W-1:0]  elevation_loss;
    logic [TOTAL_W-1:0] total_loss;

    modport source (output valid, azimuth_loss, elevation_loss, total_loss, input ready);
    modport sink   (input valid, azimuth_loss, elevation_loss, total_loss, output ready);
endinterface

// ===== rtl/core/abatt_cordic.sv =====
// ----------------------------------------------------------------------------
// abatt_cordic
// Pipelined vectoring CORDIC atan2: pre-rotation register, one step per stage, output register.
// ----------------------------------------------------------------------------
module abatt_cordic
    import abatt_pkg::*;
#(
    parameter int STEPS = 20,
    parameter int DW    = 33
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vin,
    input  logic signed [DW-1:0] y_in,
    input  logic signed [DW-1:0] x_in,
    output logic                 vout,
    output logic signed [ZW-1:0] theta
);
    localparam int XW = DW + 3;

    logic                 v_reg [0:STEPS];
    logic                 zero_reg [0:STEPS];
    logic signed [XW-1:0] x_reg [0:STEPS];
    logic signed [XW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic                 vo_reg;
    logic signed [ZW-1:0] theta_reg;

    logic signed [XW-1:0] xe, ye, x0_next, y0_next;
    logic signed [ZW-1:0] z0_next, theta_next;

    // left half-plane pre-rotation by +-90 degrees
    always_comb
    begin
        xe = XW'(x_in);
        ye = XW'(y_in);
        x0_next = xe;
        y0_next = ye;
        z0_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = QUARTER_TURN;
            end
            else
            begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [XW-1:0] x_next, y_next, xs, ys;
        logic signed [ZW-1:0] z_next, a;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            a  = $signed({{(ZW-ATAN_W){1'b0}}, ATAN_TAB[i]});
            if (y_reg[i] >= 0)
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + a;
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - a;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // zero vector and overshoot clamp
    always_comb
    begin
        theta_next = z_reg[STEPS];
        if (zero_reg[STEPS])
            theta_next = '0;
        else if (z_reg[STEPS] > HALF_TURN)
            theta_next = HALF_TURN;
        else if (z_reg[STEPS] < -HALF_TURN)
            theta_next = -HALF_TURN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            theta_reg <= theta_next;
    end

    assign vout  = vo_reg;
    assign theta = theta_reg;
endmodule

// ===== rtl/core/abatt_div.sv =====
// ----------------------------------------------------------------------------
// abatt_div
// Pipelined restoring divider, two quotient bits per stage, with bypass value.
// ----------------------------------------------------------------------------
module abatt_div
    import abatt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  logic [NUM_W-1:0]   num,
    input  logic [ANG_W-1:0]   den,
    input  sel_t               sel_in,
    output logic               vout,
    output logic [LOSS_W-1:0]  loss
);
    logic               v_reg   [0:DIV_STAGES];
    logic [NUM_W-1:0]   rem_reg [0:DIV_STAGES];
    logic [ANG_W-1:0]   den_reg [0:DIV_STAGES];
    logic [QBITS-1:0]   q_reg   [0:DIV_STAGES];
    sel_t               sel_reg [0:DIV_STAGES];

    always_comb
    begin
        v_reg[0]   = vin;
        rem_reg[0] = num;
        den_reg[0] = den;
        q_reg[0]   = '0;
        sel_reg[0] = sel_in;
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int K1 = QBITS - 1 - 2 * s;
        localparam int K0 = QBITS - 2 - 2 * s;
        logic [NUM_W-1:0] d1, d0, r1, rem_next;
        logic             b1, b0;
        logic [QBITS-1:0] q_next;

        always_comb
        begin
            d1 = NUM_W'(den_reg[s]) << K1;
            d0 = NUM_W'(den_reg[s]) << K0;
            b1 = rem_reg[s] >= d1;
            r1 = b1 ? rem_reg[s] - d1 : rem_reg[s];
            b0 = r1 >= d0;
            rem_next = b0 ? r1 - d0 : r1;
            q_next = {q_reg[s][QBITS-3:0], b1, b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_next;
                sel_reg[s+1] <= sel_reg[s];
            end
        end
    end

    assign vout = v_reg[DIV_STAGES];
    assign loss = sel_reg[DIV_STAGES].use_q ? LOSS_W'(q_reg[DIV_STAGES])
                                            : sel_reg[DIV_STAGES].fixed;
endmodule

// ===== rtl/core/antenna_beam_attenuation.sv =====
// ----------------------------------------------------------------------------
// antenna_beam_attenuation
// Directional antenna loss in azimuth and elevation for one tx/rx pair.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : valid/ready request channel, one tx/rx pair per request.
//   result : valid/ready channel, azimuth, elevation and total loss.
//   APB    : register 0 (address 0) holds max_attenuation, 1/256 dB.
// Throughput: one request per cycle while the result register is not stalled.
// Pipeline: stage A, the one-step-per-stage CORDIC, stages C, D and E, the
//   two-bits-per-stage divider and the result register.
// Reset clears all valid bits and loads max_attenuation with 5120 (20 dB).
// When the receiver stalls, the whole pipeline holds; a request is still
//   taken while the result register is empty or being drained. Nothing is
//   lost or duplicated across a stall.
// max_attenuation is sampled late in the pipe, so write it only while idle.
// ----------------------------------------------------------------------------
module antenna_beam_attenuation
    import abatt_pkg::*;
#(
    parameter int CORDIC_STEPS  = 20,
    parameter int POSITION_BITS = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    abatt_in_if.sink    pair,
    abatt_out_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PB = POSITION_BITS;
    localparam int DW = PB + 1;
    localparam int CL = CORDIC_STEPS + 2;

    logic en;
    logic [LOSS_W-1:0] max_att_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_ATT) ? {16'd0, max_att_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_att_reg <= MAX_ATT_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MAX_ATT)
            max_att_reg <= pwdata[LOSS_W-1:0];
    end

    // global advance: the pipe moves unless a full result register is stalled
    logic out_valid_reg;
    assign en = !out_valid_reg || result.ready;
    assign pair.ready = en;

    // position reinterpretation at POSITION_BITS
    function automatic logic signed [DW-1:0] sext(input logic [POS_W-1:0] v);
        logic [PB-1:0] p;
        if (PB > POS_W)
            p = PB'(v);
        else
            p = v[PB-1:0];
        return $signed({p[PB-1], p});
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp_h(input logic signed [ANG_W-1:0] h);
        if (h > HEADING_LIMIT)
            return HEADING_LIMIT;
        else if (h < -HEADING_LIMIT)
            return -HEADING_LIMIT;
        return h;
    endfunction

    // stage A: deltas and clamped headings
    logic                 va_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    side_t                sa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= pair.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= sext(pair.rx_pos_x) - sext(pair.tx_pos_x);
            dy_reg <= sext(pair.rx_pos_y) - sext(pair.tx_pos_y);
            dz_reg <= sext(pair.rx_pos_z) - sext(pair.tx_pos_z);
            sa_reg.h_az <= clamp_h(pair.azimuth_heading);
            sa_reg.w_az <= pair.azimuth_width;
            sa_reg.h_el <= clamp_h(pair.elevation_heading);
            sa_reg.w_el <= pair.elevation_width;
        end
    end

    // angle of arrival in both planes
    logic                 vc_az, vc_el;
    logic signed [ZW-1:0] th_az, th_el;

    abatt_cordic #(.STEPS(CORDIC_STEPS), .DW(DW)) u_cordic_az (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(va_reg),
        .y_in(dy_reg), .x_in(dx_reg), .vout(vc_az), .theta(th_az)
    );

    abatt_cordic #(.STEPS(CORDIC_STEPS), .DW(DW)) u_cordic_el (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(va_reg),
        .y_in(dz_reg), .x_in(dx_reg), .vout(vc_el), .theta(th_el)
    );

    // side values ride along with the CORDIC
    side_t sd_reg [0:CL-1];

    always_ff @(posedge clk)
    begin
        if (en)
            sd_reg[0] <= sa_reg;
    end

    for (genvar i = 1; i < CL; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    side_t sc_side;
    assign sc_side = sd_reg[CL-1];

    // stage C: absolute difference from heading
    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [ANG_W-1:0] h,
                                                   input logic signed [ZW-1:0] th);
        logic signed [ZW:0] d;
        d = $signed({h[ANG_W-1], h, 9'd0}) - (ZW+1)'(th);
        if (d < 0)
            d = -d;
        return d[DIFF_W-1:0];
    endfunction

    logic              vcd_reg;
    logic [DIFF_W-1:0] dc_az_reg, dc_el_reg;
    logic [ANG_W-1:0]  wc_az_reg, wc_el_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcd_reg <= 1'b0;
        else if (en)
            vcd_reg <= vc_az;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_az_reg <= abs_diff(sc_side.h_az, th_az);
            dc_el_reg <= abs_diff(sc_side.h_el, th_el);
            wc_az_reg <= sc_side.w_az;
            wc_el_reg <= sc_side.w_el;
        end
    end

    // stage D: fold into 0..180 degrees
    function automatic logic [FOLD_W-1:0] fold(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] r;
        r = FULL_TURN - d;
        if (d > r)
            return r[FOLD_W-1:0];
        return d[FOLD_W-1:0];
    endfunction

    logic              vd_reg;
    logic [FOLD_W-1:0] dd_az_reg, dd_el_reg;
    logic [ANG_W-1:0]  wd_az_reg, wd_el_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en)
            vd_reg <= vcd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_az_reg <= fold(dc_az_reg);
            dd_el_reg <= fold(dc_el_reg);
            wd_az_reg <= wc_az_reg;
            wd_el_reg <= wc_el_reg;
        end
    end

    // stage E: beam edge test, result selection and dividend
    function automatic sel_t pick(input logic [FOLD_W-1:0] d, input logic [ANG_W-1:0] w,
                                  input logic [LOSS_W-1:0] max_att);
        sel_t s;
        logic in_beam;
        in_beam = {d, 1'b0} <= {w, 9'd0};
        s.use_q = 1'b0;
        s.fixed = '0;
        if (w == OMNI_WIDTH)
            s.fixed = '0;
        else if (!in_beam)
            s.fixed = max_att;
        else if (w != '0)
            s.use_q = 1'b1;
        return s;
    endfunction

    logic             ve_reg;
    sel_t             se_az_reg, se_el_reg;
    logic [NUM_W-1:0] ne_az_reg, ne_el_reg;
    logic [ANG_W-1:0] we_az_reg, we_el_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (en)
            ve_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se_az_reg <= pick(dd_az_reg, wd_az_reg, max_att_reg);
            se_el_reg <= pick(dd_el_reg, wd_el_reg, max_att_reg);
            ne_az_reg <= NUM_W'(dd_az_reg) + {1'b0, dd_az_reg, 1'b0};
            ne_el_reg <= NUM_W'(dd_el_reg) + {1'b0, dd_el_reg, 1'b0};
            we_az_reg <= wd_az_reg;
            we_el_reg <= wd_el_reg;
        end
    end

    // in-beam loss = floor(3 * diff / width)
    logic              vq_az, vq_el;
    logic [LOSS_W-1:0] loss_az, loss_el;

    abatt_div u_div_az (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(ve_reg), .num(ne_az_reg),
        .den(we_az_reg), .sel_in(se_az_reg), .vout(vq_az), .loss(loss_az)
    );

    abatt_div u_div_el (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(ve_reg), .num(ne_el_reg),
        .den(we_el_reg), .sel_in(se_el_reg), .vout(vq_el), .loss(loss_el)
    );

    // result register
    logic [LOSS_W-1:0]  az_out_reg, el_out_reg;
    logic [TOTAL_W-1:0] tot_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vq_az;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_out_reg  <= loss_az;
            el_out_reg  <= loss_el;
            tot_out_reg <= TOTAL_W'(loss_az) + TOTAL_W'(loss_el);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.azimuth_loss   = az_out_reg;
    assign result.elevation_loss = el_out_reg;
    assign result.total_loss     = tot_out_reg;

    // checks
    a_planes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (vq_az == vq_el) && (vc_az == vc_el))
        else $error("plane pipelines out of step");

    a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> tot_out_reg == TOTAL_W'(az_out_reg) + TOTAL_W'(el_out_reg))
        else $error("total loss is not the plane sum");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pair.ready)
        else $error("request refused with empty result register");

endmodule
